FILE: sv/trajectory_radius_point_filter_assert.svh
// ----------------------------------------------------------------------------
// Trajectory radius point filter assertion macros
// Clocked property checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_RADIUS_POINT_FILTER_ASSERT_SVH
`define TRAJECTORY_RADIUS_POINT_FILTER_ASSERT_SVH

`ifndef SYNTH
`define TRPF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("trpf assertion failed");
`define TRPF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("trpf assertion failed");
`else
`define TRPF_ASSERT(lbl, clk, rst_n, prop)
`define TRPF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: sv/trpf_pkg.sv
// ----------------------------------------------------------------------------
// Trajectory radius point filter package
// Sizes, item types and function codes shared by the filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trpf_pkg;

  localparam int MAX_POSITIONS = 256;
  localparam int IDX_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  localparam int POSC_W = $clog2(MAX_POSITIONS + 1);
  localparam int CNT_W  = (IDX_W > 2) ? IDX_W : 2;
  localparam int CMP_W  = CNT_W + POSC_W;
  localparam int DIST_LAT = 3;

  localparam int COORD_W = 28;
  localparam int TAG_W   = 20;
  localparam int RAD_W   = 20;
  localparam int R2_W    = 2 * RAD_W;
  localparam int SQ_W    = 2 * COORD_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int KIDX_W  = 32;

  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_TEST   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic [1:0]                func;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic signed [COORD_W-1:0] sensor_x;
    logic signed [COORD_W-1:0] sensor_y;
    logic signed [COORD_W-1:0] sensor_z;
    logic [TAG_W-1:0]          frame_tag;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] kept_x;
    logic signed [COORD_W-1:0] kept_y;
    logic signed [COORD_W-1:0] kept_z;
    logic signed [COORD_W-1:0] kept_sensor_x;
    logic signed [COORD_W-1:0] kept_sensor_y;
    logic signed [COORD_W-1:0] kept_sensor_z;
    logic [TAG_W-1:0]          kept_frame;
    logic [KIDX_W-1:0]         out_index;
    logic                      table_overflow;
  } out_t;

endpackage

FILE: sv/trpf_cell.sv
// ----------------------------------------------------------------------------
// Trajectory radius point filter position cell
// Holds one stored position; loads on append, takes its neighbor's on rotate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trpf_cell
  import trpf_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  logic shift,
  input  pos_t wdata,
  input  pos_t nbr,
  output pos_t q
);

  pos_t q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      q_r <= wdata;
    end else if (shift) begin
      q_r <= nbr;
    end
  end

  assign q = q_r;

endmodule

FILE: sv/trpf_dist.sv
// ----------------------------------------------------------------------------
// Trajectory radius point filter distance unit
// Three-stage squared distance and strict compare against the squared radius.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trpf_dist
  import trpf_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            vld,
  input  pos_t            pt,
  input  pos_t            pos,
  input  logic [R2_W-1:0] r2,
  output logic            hit
);

  logic signed [COORD_W:0] dx, dy, dz;
  logic [COORD_W-1:0] ax_nxt, ay_nxt, az_nxt;
  logic [COORD_W-1:0] ax_r, ay_r, az_r;
  logic [SQ_W-1:0]    sx_r, sy_r, sz_r;
  logic [SUM_W-1:0]   sum;
  logic               v1_r, v2_r, hit_r;

  always_comb begin
    dx = {pt.x[COORD_W-1], pt.x} - {pos.x[COORD_W-1], pos.x};
    dy = {pt.y[COORD_W-1], pt.y} - {pos.y[COORD_W-1], pos.y};
    dz = {pt.z[COORD_W-1], pt.z} - {pos.z[COORD_W-1], pos.z};
    ax_nxt = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ay_nxt = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    az_nxt = dz[COORD_W] ? COORD_W'(-dz) : dz[COORD_W-1:0];
    sum = SUM_W'(sx_r) + SUM_W'(sy_r) + SUM_W'(sz_r);
  end

  always_ff @(posedge clk) begin
    ax_r <= ax_nxt;
    ay_r <= ay_nxt;
    az_r <= az_nxt;
    sx_r <= ax_r * ax_r;
    sy_r <= ay_r * ay_r;
    sz_r <= az_r * az_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r  <= vld;
      v2_r  <= v1_r;
      hit_r <= v2_r && (sum < SUM_W'(r2));
    end
  end

  assign hit = hit_r;

endmodule

FILE: sv/trajectory_radius_point_filter.sv
// ----------------------------------------------------------------------------
// Trajectory radius point filter
// Keeps points that lie strictly inside a radius around any stored position.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are taken with start while busy is low. Append and clear
//   items finish at the accepting edge and never raise busy. A test item
//   raises busy while the position ring rotates once, one stored position per
//   cycle into the three-stage distance unit, so the ring length sets the rate.
//   A kept point shows on out_item with out_valid high for one cycle, the
//   first cycle with busy low again. The next item may be taken in that
//   same cycle. The receiver cannot stall; results are never held.
//   cfg_we writes the keep radius; the squared radius is registered from it.
//   The user must make writes only while idle; the block does not enforce it.
//   Reset clears counters, flags and the radius to 30000; stored positions
//   are not cleared and are never read before being appended.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trajectory_radius_point_filter
  import trpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_t              in_item,
  output logic             out_valid,
  output out_t             out_item,
  input  logic             cfg_we,
  input  logic [RAD_W-1:0] cfg_wdata
);

`include "trajectory_radius_point_filter_assert.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POSC_W-1:0] pos_count_r, pos_count_nxt;
  logic              overflow_r, overflow_nxt;
  logic [KIDX_W-1:0] kept_count_r, kept_count_nxt;
  logic              hit_r, hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [RAD_W-1:0]  radius_r;
  logic [R2_W-1:0]   r2_r;
  in_t               item_r;
  out_t              out_r;

  logic  accept, append_go, rotate, issue, dist_hit, last_drain;
  pos_t  ring [MAX_POSITIONS];
  pos_t  new_pos, pt;

  assign accept    = start && !busy;
  assign append_go = accept && (in_item.func == FUNC_APPEND) &&
                     (pos_count_r < POSC_W'(MAX_POSITIONS));
  assign rotate    = (state_r == S_SCAN);
  assign issue     = rotate && (CMP_W'(cnt_r) < CMP_W'(pos_count_r));
  assign last_drain = (state_r == S_DRAIN) && (cnt_r == CNT_W'(DIST_LAT - 1));

  assign new_pos = '{x: in_item.coord_x, y: in_item.coord_y, z: in_item.coord_z};
  assign pt      = '{x: item_r.coord_x, y: item_r.coord_y, z: item_r.coord_z};

  for (genvar i = 0; i < MAX_POSITIONS; i++) begin : g_ring
    trpf_cell u_cell (
      .clk   (clk),
      .we    (append_go && (pos_count_r == POSC_W'(i))),
      .shift (rotate),
      .wdata (new_pos),
      .nbr   (ring[(i + 1) % MAX_POSITIONS]),
      .q     (ring[i])
    );
  end

  trpf_dist u_dist (
    .clk   (clk),
    .rst_n (rst_n),
    .vld   (issue),
    .pt    (pt),
    .pos   (ring[0]),
    .r2    (r2_r),
    .hit   (dist_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pos_count_nxt  = pos_count_r;
    overflow_nxt   = overflow_r;
    kept_count_nxt = kept_count_r;
    hit_nxt        = hit_r || dist_hit;
    out_valid_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_item.func)
            FUNC_APPEND: begin
              if (append_go) begin
                pos_count_nxt = pos_count_r + POSC_W'(1);
              end else begin
                overflow_nxt = 1'b1;
              end
            end
            FUNC_CLEAR: begin
              pos_count_nxt = '0;
              overflow_nxt  = 1'b0;
            end
            FUNC_TEST: begin
              state_nxt = S_SCAN;
              cnt_nxt   = '0;
              hit_nxt   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_r == CNT_W'(MAX_POSITIONS - 1)) begin
          state_nxt = S_DRAIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_DRAIN: begin
        if (last_drain) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = hit_r || dist_hit;
          if (out_valid_nxt && (kept_count_r != '1)) begin
            kept_count_nxt = kept_count_r + KIDX_W'(1);
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      pos_count_r  <= '0;
      overflow_r   <= 1'b0;
      kept_count_r <= '0;
      hit_r        <= 1'b0;
      out_valid_r  <= 1'b0;
      radius_r     <= RAD_W'(30000);
      r2_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pos_count_r  <= pos_count_nxt;
      overflow_r   <= overflow_nxt;
      kept_count_r <= kept_count_nxt;
      hit_r        <= hit_nxt;
      out_valid_r  <= out_valid_nxt;
      r2_r         <= radius_r * radius_r;
      if (cfg_we) begin
        radius_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_item.func == FUNC_TEST)) begin
      item_r <= in_item;
    end
    if (last_drain) begin
      out_r.kept_x         <= item_r.coord_x;
      out_r.kept_y         <= item_r.coord_y;
      out_r.kept_z         <= item_r.coord_z;
      out_r.kept_sensor_x  <= item_r.sensor_x;
      out_r.kept_sensor_y  <= item_r.sensor_y;
      out_r.kept_sensor_z  <= item_r.sensor_z;
      out_r.kept_frame     <= item_r.frame_tag;
      out_r.out_index      <= kept_count_r;
      out_r.table_overflow <= overflow_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `TRPF_ASSERT(a_count_bound, clk, rst_n, pos_count_r <= POSC_W'(MAX_POSITIONS))
  `TRPF_ASSERT(a_ovf_full, clk, rst_n, overflow_r |-> (pos_count_r == POSC_W'(MAX_POSITIONS)))
  `TRPF_ASSERT(a_out_after_drain, clk, rst_n, out_valid_r |-> ($past(state_r) == S_DRAIN))
  `TRPF_ASSERT(a_single_result, clk, rst_n, out_valid_r |=> !out_valid_r)
  `TRPF_ASSERT(a_no_issue_idle, clk, rst_n, (state_r == S_IDLE) |-> !issue)

endmodule
